// ----- rtl/core/mkmc_pkg.sv -----
package mkmc_pkg;

  typedef enum logic [1:0] {
    CMD_KEY_BYTE = 2'd0,
    CMD_KEY_LEN  = 2'd1,
    CMD_DATA     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  localparam int unsigned SlotW    = 4;
  localparam int unsigned PosW     = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned KeyLenW  = 6;
  localparam int unsigned CountW   = 32;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic [ByteW-1:0]   data_byte;
    logic [KeyLenW-1:0] key_length;
    logic [ByteW-1:0]   key_byte;
    logic [PosW-1:0]    position;
    logic [SlotW-1:0]   slot;
  } in_fields_t;

endpackage

// ----- rtl/core/mkmc_front.sv -----
module mkmc_front #(
  parameter int unsigned NUM_KEYWORDS = 16,
  parameter int unsigned MAX_LEN      = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  mkmc_pkg::cmd_e          cmd_i,
  input  mkmc_pkg::in_fields_t    fields_i,
  input  logic                    end_of_data_i,
  output logic                    push_o,
  output logic [NUM_KEYWORDS-1:0] match_o,
  output logic                    eod_o
);
  import mkmc_pkg::*;

  localparam int unsigned SW   = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
  localparam int unsigned LW   = $clog2(MAX_LEN);
  localparam int unsigned LENW = $clog2(MAX_LEN + 1);

  logic [ByteW-1:0] key_q [NUM_KEYWORDS][MAX_LEN];
  logic [LENW-1:0]  len_q [NUM_KEYWORDS];
  logic [ByteW-1:0] win_q [MAX_LEN];
  logic [ByteW-1:0] win_d [MAX_LEN];
  logic [LENW-1:0]  fill_q, fill_d;

  logic slot_ok, pos_ok;
  logic [SW-1:0] slot_idx;
  logic [LW-1:0] pos_idx;
  logic [LENW-1:0] len_clamped;

  assign slot_ok  = 7'(fields_i.slot) < 7'(NUM_KEYWORDS);
  assign pos_ok   = 7'(fields_i.position) < 7'(MAX_LEN);
  assign slot_idx = SW'(fields_i.slot);
  assign pos_idx  = LW'(fields_i.position);
  assign len_clamped = (7'(fields_i.key_length) > 7'(MAX_LEN)) ? LENW'(MAX_LEN)
                                                               : LENW'(fields_i.key_length);

  always_comb begin
    win_d[0] = fields_i.data_byte;
    for (int j = 1; j < MAX_LEN; j++) begin
      win_d[j] = win_q[j-1];
    end
    fill_d = (fill_q == LENW'(MAX_LEN)) ? fill_q : fill_q + LENW'(1);
  end

  always_comb begin
    for (int s = 0; s < NUM_KEYWORDS; s++) begin
      match_o[s] = (len_q[s] != '0) && (len_q[s] <= fill_d);
      for (int p = 0; p < MAX_LEN; p++) begin
        if (LENW'(p) < len_q[s]) begin
          if (key_q[s][p] != win_d[LW'(len_q[s] - LENW'(p) - LENW'(1))]) begin
            match_o[s] = 1'b0;
          end
        end
      end
    end
  end

  assign push_o = accept_i && (cmd_i == CMD_DATA);
  assign eod_o  = end_of_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_KEYWORDS; s++) begin
        len_q[s] <= '0;
        for (int p = 0; p < MAX_LEN; p++) begin
          key_q[s][p] <= '0;
        end
      end
      for (int j = 0; j < MAX_LEN; j++) begin
        win_q[j] <= '0;
      end
      fill_q <= '0;
    end else if (accept_i) begin
      unique case (cmd_i)
        CMD_KEY_BYTE: begin
          if (slot_ok && pos_ok) begin
            key_q[slot_idx][pos_idx] <= fields_i.key_byte;
          end
        end
        CMD_KEY_LEN: begin
          if (slot_ok) begin
            len_q[slot_idx] <= len_clamped;
          end
        end
        CMD_DATA: begin
          win_q  <= win_d;
          fill_q <= end_of_data_i ? '0 : fill_d;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/mkmc_queue.sv -----
module mkmc_queue #(
  parameter int unsigned WIDTH = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import mkmc_pkg::*;

  localparam int unsigned PW = $clog2(QueueDepth);

  logic [WIDTH-1:0] mem_q [QueueDepth];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      count_q;
  logic             do_pop;

  assign full_o  = count_q == (PW+1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + (PW+1)'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - (PW+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/core/mkmc_back.sv -----
module mkmc_back #(
  parameter int unsigned NUM_KEYWORDS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [NUM_KEYWORDS-1:0] match_i,
  input  logic                    eod_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [mkmc_pkg::OutDataW-1:0] out_data_o,
  output logic                    out_last_o
);
  import mkmc_pkg::*;

  localparam int unsigned SW = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
  localparam int unsigned PCW = $clog2(NUM_KEYWORDS + 1);

  typedef enum logic {
    ST_COUNT,
    ST_REPORT
  } state_e;

  state_e            state_q;
  logic [SW-1:0]     idx_q;
  logic [CountW-1:0] cnt_q [NUM_KEYWORDS];
  logic [CountW-1:0] total_q;
  logic [CountW-1:0] total_d;
  logic [PCW-1:0]    pop_cnt;
  logic [CountW:0]   total_sum;
  logic              load;
  logic              is_last;

  assign pop_o   = valid_i && (state_q == ST_COUNT);
  assign load    = !out_valid_o || out_ready_i;
  assign is_last = idx_q == SW'(NUM_KEYWORDS - 1);

  always_comb begin
    pop_cnt = '0;
    for (int s = 0; s < NUM_KEYWORDS; s++) begin
      pop_cnt = pop_cnt + PCW'(match_i[s]);
    end
    total_sum = (CountW+1)'(total_q) + (CountW+1)'(pop_cnt);
    total_d   = total_sum[CountW] ? CountMax : total_sum[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COUNT;
      idx_q       <= '0;
      total_q     <= '0;
      out_valid_o <= 1'b0;
      out_data_o  <= '0;
      out_last_o  <= 1'b0;
      for (int s = 0; s < NUM_KEYWORDS; s++) begin
        cnt_q[s] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_COUNT: begin
          if (out_valid_o && out_ready_i) begin
            out_valid_o <= 1'b0;
          end
          if (pop_o) begin
            for (int s = 0; s < NUM_KEYWORDS; s++) begin
              if (match_i[s] && cnt_q[s] != CountMax) begin
                cnt_q[s] <= cnt_q[s] + CountW'(1);
              end
            end
            total_q <= total_d;
            if (eod_i) begin
              state_q <= ST_REPORT;
              idx_q   <= '0;
            end
          end
        end
        ST_REPORT: begin
          if (load) begin
            out_valid_o <= 1'b1;
            out_data_o  <= OutDataW'({total_q, cnt_q[idx_q], SlotW'(idx_q)});
            out_last_o  <= is_last;
            if (is_last) begin
              state_q <= ST_COUNT;
              total_q <= '0;
              for (int s = 0; s < NUM_KEYWORDS; s++) begin
                cnt_q[s] <= '0;
              end
            end else begin
              idx_q <= idx_q + SW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_COUNT;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/multi_keyword_match_counter.sv -----
// Multi-keyword match counter. Command transactions load a keyword table
// (tuser 0 writes a keyword byte, 1 sets a slot length, where length 0 disables
// the slot) and data transactions (tuser 2) stream bytes; each byte is compared
// against every enabled keyword in parallel, one input transaction per cycle,
// and matches are counted per slot and in a saturating total. The data byte
// with tlast closes a file: NUM_KEYWORDS results follow in slot order, one per
// cycle while m_axis_tready is high, the final one with tlast, and the counts
// restart. Input is held off while the small internal queue is full (during a report).
module multi_keyword_match_counter #(
  parameter int unsigned NUM_KEYWORDS = 16,
  parameter int unsigned MAX_LEN      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot[3:0], position[8:4], key_byte[16:9], key_length[22:17], data_byte[30:23]
  input  logic [mkmc_pkg::InDataW-1:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_slot[3:0], match_count[35:4], total_matches[67:36]
  output logic [mkmc_pkg::OutDataW-1:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import mkmc_pkg::*;

  logic                    accept, push, full, q_valid, q_pop, eod;
  logic [NUM_KEYWORDS-1:0] match;
  logic [NUM_KEYWORDS:0]   q_out;
  in_fields_t              fields;
  cmd_e                    cmd;

  assign s_axis_tready = !full;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign fields = in_fields_t'(s_axis_tdata[$bits(in_fields_t)-1:0]);
  assign cmd    = cmd_e'(s_axis_tuser);

  mkmc_front #(
    .NUM_KEYWORDS(NUM_KEYWORDS),
    .MAX_LEN     (MAX_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (cmd),
    .fields_i     (fields),
    .end_of_data_i(s_axis_tlast),
    .push_o       (push),
    .match_o      (match),
    .eod_o        (eod)
  );

  mkmc_queue #(
    .WIDTH(NUM_KEYWORDS + 1)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({eod, match}),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  mkmc_back #(
    .NUM_KEYWORDS(NUM_KEYWORDS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .match_i    (q_out[NUM_KEYWORDS-1:0]),
    .eod_i      (q_out[NUM_KEYWORDS]),
    .pop_o      (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import mkmc_pkg::*;

  localparam int unsigned NumSlots  = 16;
  localparam int unsigned KeyMax    = 32;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    cmd_e       cmd;
    in_fields_t fields;
    logic       eod;
  } txn_t;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
    logic [CountW-1:0] total;
    logic              last;
  } report_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tlast;

  multi_keyword_match_counter DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  logic [ByteW-1:0]   kw_bytes [NumSlots][KeyMax] = '{default: '0};
  logic [KeyLenW-1:0] kw_len [NumSlots] = '{default: '0};
  logic [ByteW-1:0]   hist [KeyMax] = '{default: '0};
  int unsigned        hist_fill = 0;
  logic [CountW-1:0]  hits [NumSlots] = '{default: '0};
  logic [CountW-1:0]  hit_total = '0;

  logic [ByteW-1:0] kw_plan [NumSlots][KeyMax] = '{default: '0};
  int unsigned      kw_len_plan [NumSlots] = '{default: 0};

  txn_t    pending_txns [$];
  report_t expected_reports [$];
  int      errors = 0;
  int      n_reports = 0;
  int      n_scanned = 0;
  int      cycles = 0;
  int      base_reports;
  int      send_gap;
  int      take_gap;
  bit      hold_for_drain = 0;
  logic    in_taken_q;
  logic    out_taken_q;

  function automatic logic [CountW-1:0] bump(logic [CountW-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  task automatic queue_txn(txn_t t);
    pending_txns.insert(pending_txns.size(), t);
  endtask

  task automatic predict_counts(txn_t t);
    bit hit;
    int unsigned l;
    report_t r;
    case (t.cmd)
      CMD_KEY_BYTE: kw_bytes[t.fields.slot][t.fields.position] = t.fields.key_byte;
      CMD_KEY_LEN: kw_len[t.fields.slot] =
        (t.fields.key_length > KeyMax) ? KeyLenW'(KeyMax) : t.fields.key_length;
      CMD_DATA: begin
        for (int i = KeyMax - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = t.fields.data_byte;
        if (hist_fill < KeyMax) hist_fill++;
        for (int s = 0; s < NumSlots; s++) begin
          l = 32'(kw_len[s]);
          hit = (l != 0) && (l <= hist_fill);
          for (int p = 0; p < KeyMax; p++)
            if (hit && p < l && kw_bytes[s][p] != hist[l-1-p]) hit = 0;
          if (hit) begin
            hits[s] = bump(hits[s]);
            hit_total = bump(hit_total);
          end
        end
        if (t.eod) begin
          for (int s = 0; s < NumSlots; s++) begin
            r.slot = SlotW'(s);
            r.count = hits[s];
            r.total = hit_total;
            r.last = (s == NumSlots - 1);
            expected_reports.insert(expected_reports.size(), r);
            hits[s] = '0;
          end
          hit_total = '0;
          hist_fill = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [CountW-1:0] got, logic [CountW-1:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic txn_t mk(cmd_e c, int s, int p, int kb, int kl, int db, int e);
    txn_t t;
    t.cmd = c;
    t.fields.slot = SlotW'(s);
    t.fields.position = PosW'(p);
    t.fields.key_byte = ByteW'(kb);
    t.fields.key_length = KeyLenW'(kl);
    t.fields.data_byte = ByteW'(db);
    t.eod = (e != 0);
    return t;
  endfunction

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tdata <= '0;
      s_axis_tuser <= CMD_NONE;
      s_axis_tlast <= 0;
      send_gap <= 0;
    end else if (s_axis_tvalid && !in_taken_q) begin
    end else if (send_gap > 0) begin
      s_axis_tvalid <= 0;
      send_gap <= send_gap - 1;
    end else if (pending_txns.size() > 0 && !(hold_for_drain && expected_reports.size() > 0)) begin
      s_axis_tvalid <= 1;
      s_axis_tdata <= InDataW'(pending_txns[0].fields);
      s_axis_tuser <= pending_txns[0].cmd;
      s_axis_tlast <= pending_txns[0].eod;
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    end else begin
      s_axis_tvalid <= 0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    txn_t t;
    if (!rst_ni) begin
      in_taken_q <= 0;
      out_taken_q <= 0;
    end else begin
      in_taken_q <= s_axis_tvalid && s_axis_tready;
      out_taken_q <= m_axis_tvalid && m_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        t = pending_txns.pop_front();
        if (t.cmd == CMD_DATA) n_scanned++;
        predict_counts(t);
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    int g;
    if (!rst_ni) begin
      m_axis_tready <= 0;
      take_gap <= 0;
    end else if (out_taken_q) begin
      g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      m_axis_tready <= (g == 0);
      take_gap <= (g > 0) ? g - 1 : 0;
    end else if (take_gap > 0) begin
      m_axis_tready <= 0;
      take_gap <= take_gap - 1;
    end else begin
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk_i) begin
    report_t r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_reports++;
      if (expected_reports.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        r = expected_reports.pop_front();
        if (m_axis_tdata[3:0] != r.slot)
          report_mismatch("slot", CountW'(m_axis_tdata[3:0]), CountW'(r.slot));
        if (m_axis_tdata[35:4] != r.count) report_mismatch("count", m_axis_tdata[35:4], r.count);
        if (m_axis_tdata[67:36] != r.total) report_mismatch("total", m_axis_tdata[67:36], r.total);
        if (m_axis_tlast != r.last)
          report_mismatch("last", CountW'(m_axis_tlast), CountW'(r.last));
        if (m_axis_tdata[71:68] != 0)
          report_mismatch("pad", CountW'(m_axis_tdata[71:68]), '0);
      end
    end
  end

  task automatic add_file(int nbytes);
    int k;
    int s;
    for (int i = 0; i < nbytes; i++) begin
      s = $urandom_range(0, NumSlots - 1);
      if ($urandom_range(0, 3) == 0 && kw_len_plan[s] > 0 && i + kw_len_plan[s] < nbytes) begin
        for (k = 0; k < kw_len_plan[s]; k++)
          queue_txn(mk(CMD_DATA, $urandom, $urandom, $urandom, $urandom,
                       int'(kw_plan[s][k]), 0));
        i += kw_len_plan[s] - 1;
      end else begin
        queue_txn(mk(CMD_DATA, $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(65, 67), 0));
      end
    end
    queue_txn(mk(CMD_DATA, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(65, 67), 1));
  endtask

  task automatic load_key(int s, int l);
    kw_len_plan[s] = (l > KeyMax) ? KeyMax : l;
    for (int p = 0; p < kw_len_plan[s]; p++) begin
      kw_plan[s][p] = ByteW'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(65, 67));
      queue_txn(mk(CMD_KEY_BYTE, s, p, int'(kw_plan[s][p]), $urandom, $urandom, $urandom));
    end
    queue_txn(mk(CMD_KEY_LEN, s, $urandom, $urandom, l, $urandom, $urandom));
  endtask

  task automatic wait_drain();
    while (pending_txns.size() > 0 || expected_reports.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    // directed: extremes, oversize length, unused cmd, end mark on table cmds
    queue_txn(mk(CMD_DATA, 0, 0, 0, 0, 255, 1));
    queue_txn(mk(CMD_KEY_BYTE, 15, 31, 255, 63, 0, 1));
    queue_txn(mk(CMD_KEY_LEN, 15, 31, 0, 63, 255, 1));
    queue_txn(mk(CMD_KEY_LEN, 0, 0, 0, 1, 0, 0));
    queue_txn(mk(CMD_NONE, 15, 31, 255, 63, 0, 1));
    queue_txn(mk(CMD_DATA, 15, 31, 255, 63, 0, 0));
    queue_txn(mk(CMD_DATA, 0, 0, 0, 0, 0, 0));
    queue_txn(mk(CMD_DATA, 0, 0, 0, 32, 0, 1));
    queue_txn(mk(CMD_KEY_LEN, 0, 0, 0, 0, 0, 0));
    queue_txn(mk(CMD_KEY_LEN, 15, 0, 0, 33, 0, 0));
    for (int i = 0; i < 4; i++)
      queue_txn(mk(CMD_DATA, 0, 0, 0, 0, 255, (i == 3) ? 1 : 0));
    kw_len_plan[15] = 0;
    queue_txn(mk(CMD_KEY_LEN, 15, 0, 0, 0, 0, 0));
    wait_drain();

    for (int s = 0; s < NumSlots; s++)
      load_key(s, s == 0 ? 1 : s == 1 ? 32 : s == 2 ? 0 : $urandom_range(1, 2));
    wait_drain();
    // hold the sender after each end of file until its report has drained
    hold_for_drain = 1;
    base_reports = n_reports;
    for (int f = 0; f < 3; f++) add_file($urandom_range(8, 14));
    wait (n_reports >= base_reports + 2 * NumSlots);
    hold_for_drain = 0;
    load_key($urandom_range(0, 15), $urandom_range(1, 3));
    add_file($urandom_range(5, 10));
    wait_drain();
    repeat (40) @(posedge clk_i);
    $display("scanned %0d data bytes, checked %0d per-slot counts", n_scanned, n_reports);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
